@@ hw/rtl/modem_response_matcher_defines.svh @@
// Assertion macros for the modem response matcher checker.
// No dependencies; include by bare file name.
`ifndef MODEM_RESPONSE_MATCHER_DEFINES_SVH
`define MODEM_RESPONSE_MATCHER_DEFINES_SVH

// Checked on every edge outside reset.
`define MRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define MRM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/mrm_pkg.sv @@
// Shared types and constants for the modem response matcher.
// No dependencies.
package mrm_pkg;

  localparam int TEXT_MAX = 8;

  typedef logic [7:0] char_t;
  typedef logic [2:0] pos_t;
  typedef char_t [0:TEXT_MAX-1] text_t;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_CMD    = 2'd1,
    OP_LISTEN = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_OK      = 3'd1,
    EV_ERROR   = 3'd2,
    EV_PROMPT  = 3'd3,
    EV_UNSOL   = 3'd4,
    EV_IGNORED = 3'd5
  } event_t;

  localparam char_t CH_CR = 8'h0D;
  localparam char_t CH_LF = 8'h0A;

  // Reply texts, first character at index 0, zero padded.
  localparam text_t OK_TEXT     = {8'h4F, 8'h4B, CH_CR, CH_LF, 32'h0};
  localparam text_t ERR_TEXT    = {8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, CH_CR, CH_LF, 8'h00};
  localparam text_t PROMPT_TEXT = {CH_CR, CH_LF, 8'h3E, 8'h20, 32'h0};

  localparam pos_t OK_LEN     = 3'd4;
  localparam pos_t ERR_LEN    = 3'd7;
  localparam pos_t PROMPT_LEN = 3'd4;

  typedef struct packed {
    pos_t pos_next;
    logic done;
  } match_t;

  typedef struct packed {
    event_t     ev;
    logic [8:0] byte_count;
    logic       busy;
  } res_t;

endpackage

@@ hw/rtl/mrm_match.sv @@
// One reply matcher: advances its position on a received byte.
// Depends on mrm_pkg.
module mrm_match import mrm_pkg::*; (
  input  pos_t   pos,
  input  char_t  rx,
  input  text_t  text,
  input  pos_t   len,
  output match_t res
);

  logic hit;
  pos_t pos_inc;

  assign pos_inc = pos + 3'd1;
  assign hit     = (pos < len) && (text[pos] == rx);

  // mismatch restarts at 1 only when the byte is the first character
  assign res.pos_next = hit ? pos_inc : ((rx == text[0]) ? 3'd1 : 3'd0);
  assign res.done     = hit && (pos_inc == len);

endmodule

@@ hw/rtl/mrm_core.sv @@
// Matcher state and its one-step update for an item.
// Depends on mrm_pkg and mrm_match.
module mrm_core import mrm_pkg::*; #(
  parameter int RX_DEPTH = 256
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  go,
  input  op_t   op,
  input  char_t rx_byte,
  output res_t  res
);

  localparam int CNT_W = $clog2(RX_DEPTH + 1);
  localparam int EXT_W = (CNT_W > 9) ? CNT_W : 9;

  logic             armed, armed_next;
  logic             listen_mode, listen_mode_next;
  logic             cmd_busy, cmd_busy_next;
  logic [CNT_W-1:0] count, count_next;
  char_t            prev_byte, prev_byte_next;
  pos_t             ok_pos, ok_pos_next;
  pos_t             err_pos, err_pos_next;
  pos_t             prompt_pos, prompt_pos_next;
  event_t           ev;
  match_t           ok_m, err_m, prompt_m;
  logic [EXT_W-1:0] count_ext;

  mrm_match u_ok (
    .pos(ok_pos), .rx(rx_byte), .text(OK_TEXT), .len(OK_LEN), .res(ok_m)
  );
  mrm_match u_err (
    .pos(err_pos), .rx(rx_byte), .text(ERR_TEXT), .len(ERR_LEN), .res(err_m)
  );
  mrm_match u_prompt (
    .pos(prompt_pos), .rx(rx_byte), .text(PROMPT_TEXT), .len(PROMPT_LEN), .res(prompt_m)
  );

  always_comb begin
    armed_next       = armed;
    listen_mode_next = listen_mode;
    cmd_busy_next    = cmd_busy;
    count_next       = count;
    prev_byte_next   = prev_byte;
    ok_pos_next      = ok_pos;
    err_pos_next     = err_pos;
    prompt_pos_next  = prompt_pos;
    ev               = EV_NONE;
    case (op)
      OP_BYTE: begin
        if (!armed || (count >= CNT_W'(RX_DEPTH))) begin
          ev = EV_IGNORED;
        end else if (listen_mode && (count != '0) && (prev_byte == CH_CR) &&
                     (rx_byte == CH_LF)) begin
          armed_next       = 1'b0;
          cmd_busy_next    = 1'b0;
          listen_mode_next = 1'b0;
          ev               = EV_UNSOL;
        end else begin
          // priority chain; matchers after a completion keep their position
          ok_pos_next = ok_m.pos_next;
          if (ok_m.done) begin
            armed_next    = 1'b0;
            cmd_busy_next = 1'b0;
            ev            = EV_OK;
          end else begin
            err_pos_next = err_m.pos_next;
            if (err_m.done) begin
              armed_next    = 1'b0;
              cmd_busy_next = 1'b0;
              ev            = EV_ERROR;
            end else begin
              prompt_pos_next = prompt_m.pos_next;
              if (prompt_m.done) begin
                armed_next    = 1'b0;
                cmd_busy_next = 1'b0;
                ev            = EV_PROMPT;
              end else begin
                prev_byte_next = rx_byte;
                count_next     = count + 1'b1;
              end
            end
          end
        end
      end
      OP_CMD: begin
        if (!cmd_busy) begin
          count_next      = '0;
          prev_byte_next  = '0;
          ok_pos_next     = '0;
          err_pos_next    = '0;
          prompt_pos_next = '0;
          cmd_busy_next   = 1'b1;
          armed_next      = 1'b1;
        end
      end
      OP_LISTEN: begin
        count_next       = '0;
        prev_byte_next   = '0;
        ok_pos_next      = '0;
        err_pos_next     = '0;
        prompt_pos_next  = '0;
        listen_mode_next = 1'b1;
        armed_next       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign count_ext      = EXT_W'(count_next);
  assign res.ev         = ev;
  assign res.byte_count = count_ext[8:0];
  assign res.busy       = cmd_busy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b1;
      listen_mode <= 1'b0;
      cmd_busy    <= 1'b0;
      count       <= '0;
      prev_byte   <= '0;
      ok_pos      <= '0;
      err_pos     <= '0;
      prompt_pos  <= '0;
    end else if (go) begin
      armed       <= armed_next;
      listen_mode <= listen_mode_next;
      cmd_busy    <= cmd_busy_next;
      count       <= count_next;
      prev_byte   <= prev_byte_next;
      ok_pos      <= ok_pos_next;
      err_pos     <= err_pos_next;
      prompt_pos  <= prompt_pos_next;
    end
  end

endmodule

@@ hw/rtl/modem_response_matcher.sv @@
// Modem response matcher: one input beat per cycle while out_ready lets results
// drain, one result beat per input beat. Each beat is registered on entry; the
// matcher state and the result register update together once the result register
// is free, and a new beat is taken every cycle. Op 0 feeds a received byte
// to the OK, ERROR and prompt matchers (and the CR LF line detector in listen mode),
// op 1 arms for a command reply, op 2 arms for unsolicited lines. byte_count holds
// up to RX_DEPTH bytes, reported modulo 512.
// Depends on mrm_pkg and mrm_core.
module modem_response_matcher import mrm_pkg::*; #(
  parameter int RX_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_res,
  output logic [8:0] byte_count,
  output logic       busy_res
);

  logic  s1_valid;
  op_t   s1_op;
  char_t s1_byte;
  logic  out_free;
  logic  s1_go;
  res_t  res;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && out_free;
  assign in_ready = !s1_valid || s1_go;

  mrm_core #(.RX_DEPTH(RX_DEPTH)) u_core (
    .clk     (clk),
    .rst     (rst),
    .go      (s1_go),
    .op      (s1_op),
    .rx_byte (s1_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= op_t'(op);
      s1_byte <= rx_byte;
    end
    if (s1_go) begin
      event_res  <= res.ev;
      byte_count <= res.byte_count;
      busy_res   <= res.busy;
    end
  end

endmodule

@@ hw/rtl/mrm_checker.sv @@
// Port-level checks for the modem response matcher, bound to the top level.
// Depends on mrm_pkg and modem_response_matcher_defines.svh.
`include "modem_response_matcher_defines.svh"

module mrm_checker import mrm_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_res,
  input logic [8:0] byte_count,
  input logic       busy_res
);

  `MRM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(byte_count) && $stable(busy_res), "result beat changed while stalled")

  `MRM_ASSERT(a_ev_code, out_valid |-> (event_res == EV_NONE) || (event_res == EV_OK) || (event_res == EV_ERROR) || (event_res == EV_PROMPT) || (event_res == EV_UNSOL) || (event_res == EV_IGNORED), "undefined event code")

  `MRM_ASSERT(a_reply_idle, out_valid && ((event_res == EV_OK) || (event_res == EV_ERROR) || (event_res == EV_PROMPT)) |-> !busy_res, "busy after reply")

  `MRM_ASSERT_RST(a_rst_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind modem_response_matcher mrm_checker u_mrm_checker (.*);

@@ sim/modem_response_matcher_test.sv @@
// Self-checking testbench for modem_response_matcher: directed table, then random
// reply/line/noise traffic with random idling on both handshakes.
// Depends on mrm_pkg and the modem_response_matcher RTL.
module modem_response_matcher_test;
  import mrm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RX_DEPTH = 256;
  localparam int N_DIRECTED = 27;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CALM_ITEMS = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_BEAT = 300;
  localparam int LIMIT_NS = 5_000_000;

  // op code the block does not decode
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    char_t      b;
    logic       typed;
    res_t       want;
  } beat_t;

  localparam char_t ALPHABET [8] = '{"O", "K", "E", "R", CH_CR, CH_LF, ">", " "};

  // Directed walk; typed expectations where the answer is obvious.
  localparam beat_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{OP_BYTE,   "O",    1'b1, '{EV_NONE,    9'd1, 1'b0}},
    '{OP_BYTE,   "K",    1'b0, '0},
    '{OP_BYTE,   CH_CR,  1'b0, '0},
    '{OP_BYTE,   CH_LF,  1'b1, '{EV_OK,      9'd3, 1'b0}},
    '{OP_BYTE,   8'hFF,  1'b1, '{EV_IGNORED, 9'd3, 1'b0}},
    '{OP_SPARE,  8'h00,  1'b1, '{EV_NONE,    9'd3, 1'b0}},
    '{OP_CMD,    8'h00,  1'b1, '{EV_NONE,    9'd0, 1'b1}},
    '{OP_CMD,    8'hFF,  1'b1, '{EV_NONE,    9'd0, 1'b1}},
    '{OP_BYTE,   "E",    1'b0, '0},
    '{OP_BYTE,   "R",    1'b0, '0},
    '{OP_BYTE,   "R",    1'b0, '0},
    '{OP_BYTE,   "O",    1'b0, '0},
    '{OP_BYTE,   "R",    1'b0, '0},
    '{OP_BYTE,   CH_CR,  1'b0, '0},
    '{OP_BYTE,   CH_LF,  1'b1, '{EV_ERROR,   9'd6, 1'b0}},
    '{OP_CMD,    8'h00,  1'b0, '0},
    '{OP_BYTE,   CH_CR,  1'b0, '0},
    '{OP_BYTE,   CH_LF,  1'b0, '0},
    '{OP_BYTE,   ">",    1'b0, '0},
    '{OP_BYTE,   " ",    1'b1, '{EV_PROMPT,  9'd3, 1'b0}},
    '{OP_LISTEN, 8'h00,  1'b1, '{EV_NONE,    9'd0, 1'b0}},
    // LF as first byte after arming must not pair with anything
    '{OP_BYTE,   CH_LF,  1'b0, '0},
    '{OP_BYTE,   CH_CR,  1'b0, '0},
    '{OP_BYTE,   CH_LF,  1'b1, '{EV_UNSOL,   9'd2, 1'b0}},
    '{OP_CMD,    8'h00,  1'b0, '0},
    '{OP_LISTEN, 8'hFF,  1'b1, '{EV_NONE,    9'd0, 1'b1}},
    '{OP_BYTE,   8'h00,  1'b1, '{EV_NONE,    9'd1, 1'b1}}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] op = OP_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] event_res;
  logic [8:0] byte_count;
  logic       busy_res;

  // travels with the payload so the monitor sees it at the accepting edge
  logic       cur_typed = 1'b0;
  res_t       cur_want = '0;

  beat_t      stim_q[$];
  res_t       reply_q[$];
  int         beats_in = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         ev_seen [8] = '{default: 0};
  bit         calm = 1'b0;
  bit         hold_done = 1'b0;

  // matcher model state
  logic       st_armed = 1'b1;
  logic       st_listen = 1'b0;
  logic       st_busy = 1'b0;
  logic [8:0] st_count = '0;
  char_t      st_prev = '0;
  pos_t       st_ok = '0;
  pos_t       st_err = '0;
  pos_t       st_prompt = '0;

  always #5 clk = ~clk;

  modem_response_matcher #(.RX_DEPTH(RX_DEPTH)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_res  (event_res),
    .byte_count (byte_count),
    .busy_res   (busy_res)
  );

  // Simplified KMP step: on mismatch restart at 1 if b is the first character.
  function automatic match_t match_advance(pos_t pos, text_t txt, pos_t len, char_t b);
    match_t m;
    if (pos < len && txt[pos] == b) begin
      m.pos_next = pos + 3'd1;
      m.done = (m.pos_next == len);
    end else begin
      m.pos_next = (b == txt[0]) ? pos_t'(1) : pos_t'(0);
      m.done = 1'b0;
    end
    return m;
  endfunction

  function automatic void clear_capture();
    st_count = '0;
    st_prev = '0;
    st_ok = '0;
    st_err = '0;
    st_prompt = '0;
  endfunction

  function automatic res_t predict_reply(logic [1:0] cmd, char_t b);
    res_t   r;
    match_t m;
    event_t ev;
    ev = EV_NONE;
    case (cmd)
      OP_BYTE: begin
        if (!st_armed || st_count >= RX_DEPTH) begin
          ev = EV_IGNORED;
        end else if (st_listen && st_count != 0 && st_prev == CH_CR && b == CH_LF) begin
          st_armed = 1'b0;
          st_busy = 1'b0;
          st_listen = 1'b0;
          ev = EV_UNSOL;
        end else begin
          // matchers after the completing one keep their position
          m = match_advance(st_ok, OK_TEXT, OK_LEN, b);
          st_ok = m.pos_next;
          if (m.done) begin
            ev = EV_OK;
          end else begin
            m = match_advance(st_err, ERR_TEXT, ERR_LEN, b);
            st_err = m.pos_next;
            if (m.done) begin
              ev = EV_ERROR;
            end else begin
              m = match_advance(st_prompt, PROMPT_TEXT, PROMPT_LEN, b);
              st_prompt = m.pos_next;
              if (m.done) ev = EV_PROMPT;
            end
          end
          if (ev == EV_NONE) begin
            st_prev = b;
            st_count = st_count + 9'd1;
          end else begin
            st_armed = 1'b0;
            st_busy = 1'b0;
          end
        end
      end
      OP_CMD: begin
        if (!st_busy) begin
          clear_capture();
          st_busy = 1'b1;
          st_armed = 1'b1;
        end
      end
      OP_LISTEN: begin
        st_listen = 1'b1;
        clear_capture();
        st_armed = 1'b1;
      end
      default: ;
    endcase
    r.ev = ev;
    r.byte_count = st_count;
    r.busy = st_busy;
    return r;
  endfunction

  task automatic add_beat(logic [1:0] o, char_t b);
    beat_t bt;
    bt = '0;
    bt.op = o;
    bt.b = b;
    stim_q.push_back(bt);
  endtask

  task automatic add_text(text_t txt, int len);
    for (int k = 0; k < len; k++) add_beat(OP_BYTE, txt[k]);
  endtask

  function automatic char_t pick_char();
    if ($urandom_range(0, 1) != 0) return ALPHABET[$urandom_range(0, 7)];
    return char_t'($urandom_range(0, 255));
  endfunction

  task automatic plan_random(int total);
    int    kind;
    int    len;
    int    floods;
    text_t txt;
    floods = 0;
    while (stim_q.size() < total) begin
      // two long lines that run the byte counter into its ceiling
      if (floods < 2 && stim_q.size() > 400 + floods * 600) begin
        floods++;
        add_beat(OP_LISTEN, pick_char());
        repeat (RX_DEPTH + 3) add_beat(OP_BYTE, char_t'($urandom_range(8'h61, 8'h7A)));
        add_text(PROMPT_TEXT, 2);
        continue;
      end
      case ($urandom_range(0, 2))
        0: begin txt = OK_TEXT; len = OK_LEN; end
        1: begin txt = ERR_TEXT; len = ERR_LEN; end
        default: begin txt = PROMPT_TEXT; len = PROMPT_LEN; end
      endcase
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        // command, some chatter, then a reply that is sometimes cut short
        if ($urandom_range(0, 5) != 0) add_beat(OP_CMD, pick_char());
        repeat ($urandom_range(0, 5)) add_beat(OP_BYTE, pick_char());
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, len - 1);
        add_text(txt, len);
      end else if (kind <= 6) begin
        add_beat(OP_LISTEN, pick_char());
        repeat ($urandom_range(0, 8)) add_beat(OP_BYTE, pick_char());
        if ($urandom_range(0, 3) != 0) add_text(PROMPT_TEXT, 2);
      end else if (kind == 7) begin
        // repeated first character exercises the restart-at-1 path
        add_beat(OP_CMD, pick_char());
        add_beat(OP_BYTE, txt[0]);
        add_text(txt, len);
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 6))
          add_beat(2'($urandom_range(0, 3)), char_t'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) add_beat(OP_BYTE, pick_char());
      end
    end
  endtask

  // Sender
  initial begin
    bit gaps_on;
    gaps_on = 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) stim_q.push_back(DIRECTED_ROWS[i]);
    plan_random(N_DIRECTED + RANDOM_ITEMS);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < stim_q.size(); i++) begin
      if (i >= stim_q.size() - CALM_ITEMS) calm = 1'b1;
      if (i % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      in_valid <= 1'b1;
      op <= stim_q[i].op;
      rx_byte <= stim_q[i].b;
      cur_typed <= stim_q[i].typed;
      cur_want <= stim_q[i].want;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (8) @(posedge clk);
    $display("%0d beats sent (%0d directed), %0d results checked, %0d mismatches",
             beats_in, N_DIRECTED, results_seen, mismatches);
    $display("events seen: ok %0d, error %0d, prompt %0d, unsolicited %0d, ignored %0d",
             ev_seen[EV_OK], ev_seen[EV_ERROR], ev_seen[EV_PROMPT], ev_seen[EV_UNSOL],
             ev_seen[EV_IGNORED]);
    if (mismatches == 0) begin
      $display("modem_response_matcher_test: PASS");
    end else begin
      $display("modem_response_matcher_test: FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold to back the block up
  initial begin
    int rx_cycles;
    rx_cycles = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && (rx_cycles / 128) % 3 != 0 && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input beats, compare on output beats
  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    res_t model;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.ev = event_t'(event_res);
        got.byte_count = byte_count;
        got.busy = busy_res;
        results_seen++;
        if (!$isunknown(event_res)) ev_seen[event_res]++;
        if (reply_q.size() == 0) begin
          if (mismatches < 10)
            $display("ERROR: unexpected result ev %0d count %0d busy %0d",
                     event_res, byte_count, busy_res);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (got.ev !== want.ev || got.byte_count !== want.byte_count ||
              got.busy !== want.busy) begin
            if (mismatches < 10)
              $display("ERROR: result %0d: expected ev %0d count %0d busy %0d, got ev %0d count %0d busy %0d",
                       results_seen, want.ev, want.byte_count, want.busy,
                       event_res, byte_count, busy_res);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        model = predict_reply(op, rx_byte);
        reply_q.push_back(cur_typed ? cur_want : model);
        beats_in++;
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", reply_q.size());
    $display("modem_response_matcher_test: FAIL");
    $finish;
  end

endmodule
